[design/rcm_pkg.sv]
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants of the RGB color matrix
// Widths of samples, coefficients and intermediate sums, register reset
// values, configuration register indexes and the stage enable bundle.
// ----------------------------------------------------------------------------
package rcm_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 18;
   localparam int COEF_FRAC   = COEF_BITS - 3;
   localparam int ROW_BITS    = 3 * COEF_BITS;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   // Three products plus the rounding term need two extra bits.
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int Q_BITS      = SUM_BITS - COEF_FRAC;
   localparam int CSR_IDX_BITS = 2;

   localparam logic signed [SUM_BITS-1:0] ROUND_BIAS =
      SUM_BITS'(64'sd1 <<< (COEF_FRAC - 1));
   localparam logic signed [Q_BITS-1:0] Q_MAX =
      Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Q_BITS-1:0] Q_MIN =
      Q_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // Identity matrix: 1.0 on the diagonal.
   localparam logic [ROW_BITS-1:0] ROW0_RESET = ROW_BITS'(1) << COEF_FRAC;
   localparam logic [ROW_BITS-1:0] ROW1_RESET = ROW_BITS'(1) << (COEF_FRAC + COEF_BITS);
   localparam logic [ROW_BITS-1:0] ROW2_RESET =
      ROW_BITS'(1) << (COEF_FRAC + 2 * COEF_BITS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW0 = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW1 = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW2 = 2'd2;

   // Load enables of the three pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

[design/rcm_channel.sv]
// ----------------------------------------------------------------------------
// rcm_channel: one output channel of the color matrix
// Stage 1 multiplies, stage 2 adds the products and the rounding term,
// stage 3 shifts and saturates.
// ----------------------------------------------------------------------------
module rcm_channel (
   input  logic                                    clock,
   input  rcm_pkg::stage_en_type                   en,
   input  logic [rcm_pkg::ROW_BITS-1:0]            row,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  red,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  green,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  blue,
   output logic signed [rcm_pkg::SAMPLE_BITS-1:0]  result,
   output logic                                    sat
);

   logic signed [rcm_pkg::COEF_BITS-1:0] c0;
   logic signed [rcm_pkg::COEF_BITS-1:0] c1;
   logic signed [rcm_pkg::COEF_BITS-1:0] c2;

   logic signed [rcm_pkg::PROD_BITS-1:0] p0_in, p0_ff;
   logic signed [rcm_pkg::PROD_BITS-1:0] p1_in, p1_ff;
   logic signed [rcm_pkg::PROD_BITS-1:0] p2_in, p2_ff;
   logic signed [rcm_pkg::SUM_BITS-1:0]  sum_in, sum_ff;
   logic signed [rcm_pkg::Q_BITS-1:0]    q;
   logic signed [rcm_pkg::SAMPLE_BITS-1:0] result_in, result_ff;
   logic                                 sat_in, sat_ff;

   assign c0 = row[rcm_pkg::COEF_BITS-1:0];
   assign c1 = row[2*rcm_pkg::COEF_BITS-1:rcm_pkg::COEF_BITS];
   assign c2 = row[3*rcm_pkg::COEF_BITS-1:2*rcm_pkg::COEF_BITS];

   assign p0_in = c0 * red;
   assign p1_in = c1 * green;
   assign p2_in = c2 * blue;

   assign sum_in = rcm_pkg::SUM_BITS'(p0_ff) + rcm_pkg::SUM_BITS'(p1_ff)
                 + rcm_pkg::SUM_BITS'(p2_ff) + rcm_pkg::ROUND_BIAS;

   // Arithmetic shift gives a floor, so with the half LSB added ties go up.
   assign q = rcm_pkg::Q_BITS'(sum_ff >>> rcm_pkg::COEF_FRAC);

   always_comb begin
      if (q > rcm_pkg::Q_MAX) begin
         result_in = rcm_pkg::SAMPLE_BITS'(rcm_pkg::Q_MAX);
         sat_in    = 1'b1;
      end else if (q < rcm_pkg::Q_MIN) begin
         result_in = rcm_pkg::SAMPLE_BITS'(rcm_pkg::Q_MIN);
         sat_in    = 1'b1;
      end else begin
         result_in = q[rcm_pkg::SAMPLE_BITS-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (en.s2) begin
         sum_ff <= sum_in;
      end
      if (en.s3) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

[design/rgb_color_matrix_3x3.sv]
// ----------------------------------------------------------------------------
// rgb_color_matrix_3x3: fixed-point 3x3 color space conversion
// Each pixel item is multiplied by a programmable coefficient matrix; each
// output channel is rounded, shifted and saturated, with a clipped flag.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall red, green, blue (Q7.16), last
//   rsp      out        rsp_valid/rsp_stall red, green, blue (Q7.16), last, clipped
//   csr      in         csr_valid/csr_ready row index (0..2), 54-bit row data
//
// Results leave the output register on rsp_valid, one item per cycle while
// rsp_stall is low. The three stages are multiply, three-input add with
// rounding, and shift with saturation.
// Reset (synchronous, active high) empties the pipeline and loads the
// identity matrix. Each stage takes a new item when it is empty or when its
// contents move on, so bubbles close up and a stalled result holds in the
// output register while earlier stages still fill.
// ----------------------------------------------------------------------------
module rgb_color_matrix_3x3 (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  req_red_in,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  req_green_in,
   input  logic signed [rcm_pkg::SAMPLE_BITS-1:0]  req_blue_in,
   input  logic                                    req_last_pixel,

   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_red_out,
   output logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_green_out,
   output logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_blue_out,
   output logic                                    rsp_last_out,
   output logic                                    rsp_clipped,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rcm_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [rcm_pkg::ROW_BITS-1:0]            csr_wdata
);

   logic [rcm_pkg::ROW_BITS-1:0] row0_in, row0_ff;
   logic [rcm_pkg::ROW_BITS-1:0] row1_in, row1_ff;
   logic [rcm_pkg::ROW_BITS-1:0] row2_in, row2_ff;

   logic v1_in, v1_ff;
   logic v2_in, v2_ff;
   logic v3_in, v3_ff;
   logic last1_ff, last2_ff, last3_ff;
   logic ready1, ready2, ready3;
   rcm_pkg::stage_en_type en;
   logic sat_r, sat_g, sat_b;

   // ------------------------------------------------------------------
   // Configuration registers. Writes are taken every cycle; an index
   // beyond the last row is dropped.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      row0_in = row0_ff;
      row1_in = row1_ff;
      row2_in = row2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rcm_pkg::CSR_ROW0: row0_in = csr_wdata;
            rcm_pkg::CSR_ROW1: row1_in = csr_wdata;
            rcm_pkg::CSR_ROW2: row2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= rcm_pkg::ROW0_RESET;
         row1_ff <= rcm_pkg::ROW1_RESET;
         row2_ff <= rcm_pkg::ROW2_RESET;
      end else begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
         row2_ff <= row2_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage may load when it is empty or when
   // the stage after it is loading.
   // ------------------------------------------------------------------
   assign ready3 = !v3_ff || !rsp_stall;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_stall = !ready1;

   assign en.s1 = ready1 && req_valid;
   assign en.s2 = ready2 && v1_ff;
   assign en.s3 = ready3 && v2_ff;

   assign v1_in = ready1 ? req_valid : v1_ff;
   assign v2_in = ready2 ? v1_ff     : v2_ff;
   assign v3_in = ready3 ? v2_ff     : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // The last-pixel marker travels alongside the datapath.
   always_ff @(posedge clock) begin
      if (en.s1) begin
         last1_ff <= req_last_pixel;
      end
      if (en.s2) begin
         last2_ff <= last1_ff;
      end
      if (en.s3) begin
         last3_ff <= last2_ff;
      end
   end

   // ------------------------------------------------------------------
   // One datapath per output channel, all sharing the same enables.
   // ------------------------------------------------------------------
   rcm_channel u_red (
      .clock  (clock),
      .en     (en),
      .row    (row0_ff),
      .red    (req_red_in),
      .green  (req_green_in),
      .blue   (req_blue_in),
      .result (rsp_red_out),
      .sat    (sat_r)
   );

   rcm_channel u_green (
      .clock  (clock),
      .en     (en),
      .row    (row1_ff),
      .red    (req_red_in),
      .green  (req_green_in),
      .blue   (req_blue_in),
      .result (rsp_green_out),
      .sat    (sat_g)
   );

   rcm_channel u_blue (
      .clock  (clock),
      .en     (en),
      .row    (row2_ff),
      .red    (req_red_in),
      .green  (req_green_in),
      .blue   (req_blue_in),
      .result (rsp_blue_out),
      .sat    (sat_b)
   );

   assign rsp_valid    = v3_ff;
   assign rsp_last_out = last3_ff;
   assign rsp_clipped  = sat_r || sat_g || sat_b;

endmodule

[design/rcm_checker.sv]
// ----------------------------------------------------------------------------
// rcm_checker: port-level checks for the RGB color matrix
// Watches latency, flow control and the saturation flag from the ports.
// ----------------------------------------------------------------------------
module rcm_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_red_out,
   input logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_green_out,
   input logic signed [rcm_pkg::SAMPLE_BITS-1:0]  rsp_blue_out,
   input logic                                    rsp_clipped
);

   localparam logic signed [rcm_pkg::SAMPLE_BITS-1:0] OUT_MAX =
      rcm_pkg::SAMPLE_BITS'(rcm_pkg::Q_MAX);
   localparam logic signed [rcm_pkg::SAMPLE_BITS-1:0] OUT_MIN =
      rcm_pkg::SAMPLE_BITS'(rcm_pkg::Q_MIN);

   // A result that is held back must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // With no output stall, an accepted item reaches the output register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not reach the output in time");

   // An empty output register means the pipeline can always take an item.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is empty");

   // A clipped result carries at least one channel at a rail.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_red_out == OUT_MAX || rsp_red_out == OUT_MIN ||
          rsp_green_out == OUT_MAX || rsp_green_out == OUT_MIN ||
          rsp_blue_out == OUT_MAX || rsp_blue_out == OUT_MIN))
      else $error("clipped flag without a saturated channel");

endmodule

bind rgb_color_matrix_3x3 rcm_checker u_rcm_checker (.*);
